### design/tmla_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the tile mosaic layout address block
// no dependencies; imported by the top level and its checker

package tmla_pkg;

  localparam int unsigned AddrW    = 5;   // eight 32-bit registers
  localparam int unsigned DivW     = 36;  // shared divider operand width
  localparam int unsigned DivCntW  = 6;   // holds DivW
  localparam int unsigned MulAW    = 20;
  localparam int unsigned MulBW    = 16;
  localparam int unsigned MaxTiles = 64;
  localparam int unsigned CtuSize  = 64;
  localparam int unsigned CtuShift = $clog2(CtuSize);

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrNoTiles  = 2'd1,
    ErrBadCount = 2'd2,
    ErrTooLarge = 2'd3
  } tmla_err_e;

  typedef enum logic [2:0] {
    RegHrCount = 3'd0,
    RegLrCount = 3'd1,
    RegHrSize  = 3'd2,
    RegLrSize  = 3'd3,
    RegHrRows  = 3'd4,
    RegHrCols  = 3'd5,
    RegLrRows  = 3'd6,
    RegLrCols  = 3'd7
  } tmla_reg_e;

endpackage

### design/tile_mosaic_layout_address.sv
`timescale 1ns / 1ps
// tile mosaic layout address: plans a merged hr/lr tile picture and answers
// per-index address queries; depends on tmla_pkg
//
// usage
// - configuration goes through the apb port: eight registers at byte
//   addresses 0x00..0x1c (tile counts, tile sizes, optional tile grids);
//   pready is always high, reads return the stored value
// - a query item is taken when start is high and busy is low; busy then
//   stays high until the result has been shown
// - the result is shown for exactly one cycle with result_valid_o high;
//   the receiver cannot stall, so nothing is held back or queued
// - divisions, modulos and gcd steps run on one shared restoring divider,
//   36 bits, one quotient bit a cycle; each division runs as an issue,
//   36 steps and a hand-over; the /ctu scalings are shifts and the
//   shared 20x16 multiplier is combinational
// - an error found in the early checks gives the result in the cycle after
//   the item is taken; a given single-resolution grid needs at most one
//   division, a given mixed grid at most four; a computed layout adds the
//   square root and the divisor search (up to eight divisions), and a
//   mixed one two euclid gcd runs (up to ~24 steps on 16-bit heights)
// - one item at a time: the next item can be taken at the end of the cycle
//   after the result
// - reset clears the configuration registers and returns the sequencer to idle

module tile_mosaic_layout_address (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmla_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [6:0]                  query_index_i,
  output logic                        result_valid_o,
  output logic [19:0]                 tile_address_o,
  output logic                        tile_in_range_o,
  output logic                        first_tile_o,
  output logic [9:0]                  column_width_ctus_o,
  output logic                        column_in_range_o,
  output logic [15:0]                 merged_width_o,
  output logic [15:0]                 merged_height_o,
  output logic [7:0]                  num_columns_o,
  output logic [1:0]                  error_code_o
);
  import tmla_pkg::*;

  typedef enum logic [27:0] {
    StIdle    = 28'h0000001,
    StGcd     = 28'h0000002,
    StLcmDiv  = 28'h0000004,
    StLcmMul  = 28'h0000008,
    StSqrt    = 28'h0000010,
    StStep    = 28'h0000020,
    StXDiv    = 28'h0000040,
    StHgtMul  = 28'h0000080,
    StChk     = 28'h0000100,
    StLrrDiv  = 28'h0000200,
    StHrcDiv  = 28'h0000400,
    StLrcDiv  = 28'h0000800,
    StPwMul1  = 28'h0001000,
    StPwMul2  = 28'h0002000,
    StFinW    = 28'h0004000,
    StFinH    = 28'h0008000,
    StChk3    = 28'h0010000,
    StADiv    = 28'h0020000,
    StAMul1   = 28'h0040000,
    StADiv1   = 28'h0080000,
    StAMul2   = 28'h0100000,
    StADiv2   = 28'h0200000,
    StAMul3   = 28'h0400000,
    StADiv3   = 28'h0800000,
    StAMul4   = 28'h1000000,
    StADiv4   = 28'h2000000,
    StCwDiv   = 28'h4000000,
    StOut     = 28'h8000000
  } tmla_state_e;

  // configuration registers
  logic [6:0]  hr_cnt_q, lr_cnt_q, hr_rows_cfg_q, hr_cols_cfg_q, lr_rows_cfg_q, lr_cols_cfg_q;
  logic [31:0] hr_size_q, lr_size_q;
  logic [15:0] hw, hh, lw, lh;
  logic        cfg_wr;
  tmla_reg_e   cfg_idx;

  // sequencer and working registers
  tmla_state_e       state_q, state_d;
  logic              issued_q, issued_d;
  logic [6:0]        q_q, q_d;
  tmla_err_e         err_q, err_d;
  logic              mixed_q, mixed_d, hrside_q, hrside_d, ceil_q, ceil_d, lcm2_q, lcm2_d;
  logic [6:0]        sqn_q, sqn_d;
  logic [3:0]        r_q, r_d;
  logic [15:0]       ga_q, ga_d, gb_q, gb_d;
  logic [DivW-1:0]   tmp_q, tmp_d, lr_rows_q, lr_rows_d, ph_q, ph_d, prod_q, prod_d;
  logic [DivW-1:0]   acc_q, acc_d;
  logic [MulAW-1:0]  hc_q, hc_d;
  logic [6:0]        hr_cols_q, hr_cols_d, lr_cols_q, lr_cols_d, qt_q, qt_d, rm_q, rm_d;
  logic [23:0]       pw_q, pw_d;
  logic              tin_q, tin_d, hrsel_q, hrsel_d;
  logic [9:0]        cw_q, cw_d;

  // shared divider
  logic [DivW-1:0]    dv_rem_q, dv_rem_d, dv_quo_q, dv_quo_d, dv_den_q, dv_den_d;
  logic [DivCntW-1:0] dv_cnt_q, dv_cnt_d;
  logic               dv_run_q, dv_run_d, dv_done_q, dv_done_d;
  logic [DivW:0]      dv_trial;
  logic               dv_ge;
  logic               div_req;
  logic [DivW-1:0]    div_a, div_b;

  // shared multiplier
  logic [MulAW-1:0]       mul_a;
  logic [MulBW-1:0]       mul_b;
  logic [MulAW+MulBW-1:0] mul_p;

  logic [3:0]  sq_t;
  logic [7:0]  cols;
  logic [7:0]  tot_cnt;
  logic [6:0]  idx_i;
  logic        ok;

  assign hw = hr_size_q[15:0];
  assign hh = hr_size_q[31:16];
  assign lw = lr_size_q[15:0];
  assign lh = lr_size_q[31:16];

  // ---------------------------------------------------------------- apb
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = tmla_reg_e'(paddr[AddrW-1:2]);

  always_comb begin
    case (cfg_idx)
      RegHrCount: prdata = {25'd0, hr_cnt_q};
      RegLrCount: prdata = {25'd0, lr_cnt_q};
      RegHrSize:  prdata = hr_size_q;
      RegLrSize:  prdata = lr_size_q;
      RegHrRows:  prdata = {25'd0, hr_rows_cfg_q};
      RegHrCols:  prdata = {25'd0, hr_cols_cfg_q};
      RegLrRows:  prdata = {25'd0, lr_rows_cfg_q};
      RegLrCols:  prdata = {25'd0, lr_cols_cfg_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hr_cnt_q      <= '0;
      lr_cnt_q      <= '0;
      hr_size_q     <= '0;
      lr_size_q     <= '0;
      hr_rows_cfg_q <= '0;
      hr_cols_cfg_q <= '0;
      lr_rows_cfg_q <= '0;
      lr_cols_cfg_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegHrCount: hr_cnt_q      <= pwdata[6:0];
        RegLrCount: lr_cnt_q      <= pwdata[6:0];
        RegHrSize:  hr_size_q     <= pwdata;
        RegLrSize:  lr_size_q     <= pwdata;
        RegHrRows:  hr_rows_cfg_q <= pwdata[6:0];
        RegHrCols:  hr_cols_cfg_q <= pwdata[6:0];
        RegLrRows:  lr_rows_cfg_q <= pwdata[6:0];
        RegLrCols:  lr_cols_cfg_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- datapath
  assign mul_p   = mul_a * mul_b;
  assign sq_t    = ceil_q ? r_q : r_q + 4'd1;
  assign cols    = {1'b0, hr_cols_q} + {1'b0, lr_cols_q};
  assign tot_cnt = {1'b0, hr_cnt_q} + {1'b0, lr_cnt_q};
  assign idx_i   = hrsel_q ? q_q : q_q - hr_cnt_q;
  assign dv_trial = {dv_rem_q, dv_quo_q[DivW-1]};
  assign dv_ge    = dv_trial >= {1'b0, dv_den_q};

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    q_d       = q_q;
    err_d     = err_q;
    mixed_d   = mixed_q;
    hrside_d  = hrside_q;
    ceil_d    = ceil_q;
    lcm2_d    = lcm2_q;
    sqn_d     = sqn_q;
    r_d       = r_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    tmp_d     = tmp_q;
    lr_rows_d = lr_rows_q;
    ph_d      = ph_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    hc_d      = hc_q;
    hr_cols_d = hr_cols_q;
    lr_cols_d = lr_cols_q;
    qt_d      = qt_q;
    rm_d      = rm_q;
    pw_d      = pw_q;
    tin_d     = tin_q;
    hrsel_d   = hrsel_q;
    cw_d      = cw_q;
    div_req   = 1'b0;
    div_a     = '0;
    div_b     = '0;
    mul_a     = '0;
    mul_b     = '0;

    case (state_q)
      StIdle: begin
        if (start) begin
          q_d       = query_index_i;
          err_d     = ErrNone;
          issued_d  = 1'b0;
          hr_cols_d = '0;
          lr_cols_d = '0;
          acc_d     = '0;
          cw_d      = '0;
          tin_d     = 1'b0;
          pw_d      = '0;
          ph_d      = '0;
          mixed_d   = 1'b0;
          hrside_d  = hr_cnt_q != 7'd0;
          r_d       = '0;
          ceil_d    = 1'b0;
          lcm2_d    = 1'b0;
          sqn_d     = (hr_cnt_q != 7'd0) ? hr_cnt_q : lr_cnt_q;
          if (hr_cnt_q == 7'd0 && lr_cnt_q == 7'd0) begin
            err_d   = ErrNoTiles;
            state_d = StOut;
          end else if ({2'b0, hr_cnt_q} > 9'(MaxTiles) || {2'b0, lr_cnt_q} > 9'(MaxTiles)) begin
            err_d   = ErrBadCount;
            state_d = StOut;
          end else if (hr_cnt_q != 7'd0 && hr_rows_cfg_q != 7'd0 && hr_cols_cfg_q == 7'd0) begin
            err_d   = ErrBadCount;
            state_d = StOut;
          end else if (hr_cnt_q != 7'd0 && lr_cnt_q != 7'd0) begin
            mixed_d = 1'b1;
            if (hr_rows_cfg_q == 7'd0) begin
              if (hh == 16'd0 || lh == 16'd0) begin
                err_d   = ErrBadCount;
                state_d = StOut;
              end else begin
                ga_d    = hh;
                gb_d    = lh;
                state_d = StGcd;
              end
            end else begin
              hc_d    = {13'd0, hr_rows_cfg_q};
              state_d = StHgtMul;
            end
          end else if (hr_cnt_q != 7'd0) begin
            if (hr_rows_cfg_q == 7'd0) begin
              state_d = StSqrt;
            end else begin
              hc_d      = {13'd0, hr_rows_cfg_q};
              hr_cols_d = hr_cols_cfg_q;
              state_d   = StFinW;
            end
          end else begin
            if (lr_rows_cfg_q == 7'd0) begin
              state_d = StSqrt;
            end else if (lr_cols_cfg_q == 7'd0) begin
              err_d   = ErrBadCount;
              state_d = StOut;
            end else begin
              lr_rows_d = {29'd0, lr_rows_cfg_q};
              lr_cols_d = lr_cols_cfg_q;
              state_d   = StFinW;
            end
          end
        end
      end

      // euclid: g ends in ga
      StGcd: begin
        if (gb_q == 16'd0) begin
          state_d = StLcmDiv;
        end else begin
          div_req = 1'b1;
          div_a   = DivW'(ga_q);
          div_b   = DivW'(gb_q);
          if (dv_done_q) begin
            ga_d     = gb_q;
            gb_d     = dv_rem_q[15:0];
            issued_d = 1'b0;
          end
        end
      end

      StLcmDiv: begin
        div_req = 1'b1;
        div_a   = lcm2_q ? tmp_q : DivW'(hh);
        div_b   = DivW'(ga_q);
        if (dv_done_q) begin
          prod_d   = dv_quo_q;
          issued_d = 1'b0;
          state_d  = StLcmMul;
        end
      end

      StLcmMul: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = lcm2_q ? {12'd0, r_q} : lh;
        if (lcm2_q) begin
          hc_d    = mul_p[MulAW-1:0];
          state_d = StHgtMul;
        end else begin
          tmp_d   = mul_p;
          r_d     = '0;
          ceil_d  = 1'b1;
          sqn_d   = hr_cnt_q;
          state_d = StSqrt;
        end
      end

      // integer square root by counting up, one candidate a cycle
      StSqrt: begin
        mul_a = {16'd0, sq_t};
        mul_b = {12'd0, sq_t};
        if (ceil_q ? (mul_p < 36'(sqn_q)) : (mul_p <= 36'(sqn_q))) begin
          r_d = r_q + 4'd1;
        end else begin
          state_d = StStep;
        end
      end

      // step rows down to a divisor of the count
      StStep: begin
        if (r_q == 4'd0) begin
          state_d = mixed_q ? StXDiv : StFinW;
        end else begin
          div_req = 1'b1;
          div_a   = DivW'(sqn_q);
          div_b   = DivW'(r_q);
          if (dv_done_q) begin
            issued_d = 1'b0;
            if (dv_rem_q != '0) begin
              r_d = r_q - 4'd1;
            end else if (mixed_q) begin
              state_d = StXDiv;
            end else if (hrside_q) begin
              hc_d      = MulAW'(r_q);
              hr_cols_d = dv_quo_q[6:0];
              state_d   = StFinW;
            end else begin
              lr_rows_d = DivW'(r_q);
              lr_cols_d = dv_quo_q[6:0];
              state_d   = StFinW;
            end
          end
        end
      end

      StXDiv: begin
        div_req = 1'b1;
        div_a   = tmp_q;
        div_b   = DivW'(hh);
        if (dv_done_q) begin
          issued_d = 1'b0;
          tmp_d    = dv_quo_q;
          ga_d     = dv_quo_q[15:0];
          gb_d     = {12'd0, r_q};
          lcm2_d   = 1'b1;
          state_d  = StGcd;
        end
      end

      StHgtMul: begin
        mul_a   = hc_q;
        mul_b   = hh;
        tmp_d   = mul_p;
        state_d = StChk;
      end

      StChk: begin
        if (tmp_q == '0 || hc_q == '0 || lh == 16'd0) begin
          err_d   = ErrBadCount;
          state_d = StOut;
        end else begin
          state_d = StLrrDiv;
        end
      end

      StLrrDiv: begin
        div_req = 1'b1;
        div_a   = tmp_q;
        div_b   = DivW'(lh);
        if (dv_done_q) begin
          issued_d = 1'b0;
          if (dv_rem_q != '0) begin
            err_d   = ErrBadCount;
            state_d = StOut;
          end else begin
            lr_rows_d = dv_quo_q;
            state_d   = StHrcDiv;
          end
        end
      end

      StHrcDiv: begin
        div_req = 1'b1;
        div_a   = DivW'(hr_cnt_q);
        div_b   = DivW'(hc_q);
        if (dv_done_q) begin
          issued_d = 1'b0;
          if (dv_rem_q != '0) begin
            err_d   = ErrBadCount;
            state_d = StOut;
          end else begin
            hr_cols_d = dv_quo_q[6:0];
            state_d   = StLrcDiv;
          end
        end
      end

      // leftover lr column rounds up
      StLrcDiv: begin
        div_req = 1'b1;
        div_a   = DivW'(lr_cnt_q);
        div_b   = lr_rows_q;
        if (dv_done_q) begin
          issued_d  = 1'b0;
          lr_cols_d = dv_quo_q[6:0] + ((dv_rem_q != '0) ? 7'd1 : 7'd0);
          ph_d      = tmp_q;
          state_d   = StPwMul1;
        end
      end

      StPwMul1: begin
        mul_a   = MulAW'(hr_cols_q);
        mul_b   = hw;
        pw_d    = mul_p[23:0];
        state_d = StPwMul2;
      end

      StPwMul2: begin
        mul_a   = MulAW'(lr_cols_q);
        mul_b   = lw;
        pw_d    = pw_q + mul_p[23:0];
        state_d = StChk3;
      end

      StFinW: begin
        mul_a   = MulAW'(hrside_q ? hr_cols_q : lr_cols_q);
        mul_b   = hrside_q ? hw : lw;
        pw_d    = mul_p[23:0];
        state_d = StFinH;
      end

      StFinH: begin
        mul_a   = hrside_q ? hc_q : lr_rows_q[MulAW-1:0];
        mul_b   = hrside_q ? hh : lh;
        ph_d    = mul_p;
        state_d = StChk3;
      end

      StChk3: begin
        if (pw_q > 24'h00FFFF || ph_q > 36'h00000FFFF || cols > 8'd128) begin
          err_d   = ErrTooLarge;
          state_d = StOut;
        end else if ({1'b0, q_q} < tot_cnt) begin
          tin_d   = 1'b1;
          hrsel_d = q_q < hr_cnt_q;
          state_d = StADiv;
        end else begin
          state_d = StCwDiv;
        end
      end

      // address: (i % rows) * th / ctu * pw / ctu + (i / rows) * tw / ctu + xoff
      StADiv: begin
        div_req = 1'b1;
        div_a   = DivW'(idx_i);
        div_b   = hrsel_q ? DivW'(hc_q) : lr_rows_q;
        if (dv_done_q) begin
          issued_d = 1'b0;
          qt_d     = dv_quo_q[6:0];
          rm_d     = dv_rem_q[6:0];
          state_d  = StAMul1;
        end
      end

      StAMul1: begin
        mul_a   = MulAW'(rm_q);
        mul_b   = hrsel_q ? hh : lh;
        prod_d  = mul_p;
        state_d = StADiv1;
      end

      // ctu scalings are plain shifts
      StADiv1: begin
        prod_d  = prod_q >> CtuShift;
        state_d = StAMul2;
      end

      StAMul2: begin
        mul_a   = prod_q[MulAW-1:0];
        mul_b   = pw_q[15:0];
        prod_d  = mul_p;
        state_d = StADiv2;
      end

      StADiv2: begin
        acc_d   = prod_q >> CtuShift;
        state_d = StAMul3;
      end

      StAMul3: begin
        mul_a   = MulAW'(qt_q);
        mul_b   = hrsel_q ? hw : lw;
        prod_d  = mul_p;
        state_d = StADiv3;
      end

      StADiv3: begin
        acc_d   = acc_q + (prod_q >> CtuShift);
        state_d = hrsel_q ? StCwDiv : StAMul4;
      end

      // lr tiles sit right of the hr columns
      StAMul4: begin
        mul_a   = MulAW'(hr_cols_q);
        mul_b   = hw;
        prod_d  = mul_p;
        state_d = StADiv4;
      end

      StADiv4: begin
        acc_d   = acc_q + (prod_q >> CtuShift);
        state_d = StCwDiv;
      end

      // a 16-bit width over the ctu size always fits ten bits
      StCwDiv: begin
        if ({1'b0, q_q} < cols) begin
          cw_d = 10'(((q_q < hr_cols_q) ? hw : lw) >> CtuShift);
        end
        state_d = StOut;
      end

      StOut: begin
        state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (div_req && !issued_q) begin
      issued_d = 1'b1;
    end
  end

  // shared restoring divider, one quotient bit a cycle
  always_comb begin
    dv_rem_d  = dv_rem_q;
    dv_quo_d  = dv_quo_q;
    dv_den_d  = dv_den_q;
    dv_cnt_d  = dv_cnt_q;
    dv_run_d  = dv_run_q;
    dv_done_d = 1'b0;
    if (div_req && !issued_q) begin
      dv_rem_d = '0;
      dv_quo_d = div_a;
      dv_den_d = div_b;
      dv_cnt_d = DivCntW'(DivW);
      dv_run_d = 1'b1;
    end else if (dv_run_q) begin
      dv_rem_d = dv_ge ? DivW'(dv_trial - {1'b0, dv_den_q}) : dv_trial[DivW-1:0];
      dv_quo_d = {dv_quo_q[DivW-2:0], dv_ge};
      dv_cnt_d = dv_cnt_q - DivCntW'(1);
      if (dv_cnt_q == DivCntW'(1)) begin
        dv_run_d  = 1'b0;
        dv_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      issued_q  <= 1'b0;
      dv_run_q  <= 1'b0;
      dv_done_q <= 1'b0;
      dv_cnt_q  <= '0;
    end else begin
      state_q   <= state_d;
      issued_q  <= issued_d;
      dv_run_q  <= dv_run_d;
      dv_done_q <= dv_done_d;
      dv_cnt_q  <= dv_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    err_q     <= err_d;
    mixed_q   <= mixed_d;
    hrside_q  <= hrside_d;
    ceil_q    <= ceil_d;
    lcm2_q    <= lcm2_d;
    sqn_q     <= sqn_d;
    r_q       <= r_d;
    ga_q      <= ga_d;
    gb_q      <= gb_d;
    tmp_q     <= tmp_d;
    lr_rows_q <= lr_rows_d;
    ph_q      <= ph_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    hc_q      <= hc_d;
    hr_cols_q <= hr_cols_d;
    lr_cols_q <= lr_cols_d;
    qt_q      <= qt_d;
    rm_q      <= rm_d;
    pw_q      <= pw_d;
    tin_q     <= tin_d;
    hrsel_q   <= hrsel_d;
    cw_q      <= cw_d;
    dv_rem_q  <= dv_rem_d;
    dv_quo_q  <= dv_quo_d;
    dv_den_q  <= dv_den_d;
  end

  // ----------------------------------------------------------- results
  // any error clears every field but the error code
  assign ok                  = err_q == ErrNone;
  assign busy                = state_q != StIdle;
  assign result_valid_o      = state_q == StOut;
  assign error_code_o        = err_q;
  assign tile_in_range_o     = ok & tin_q;
  assign tile_address_o      = !(ok && tin_q) ? 20'd0 :
                               (acc_q > 36'h0000FFFFF) ? 20'hFFFFF : acc_q[19:0];
  assign first_tile_o        = ok & (q_q == 7'd0);
  assign column_in_range_o   = ok & ({1'b0, q_q} < cols);
  assign column_width_ctus_o = ok ? cw_q : 10'd0;
  assign merged_width_o      = ok ? pw_q[15:0] : 16'd0;
  assign merged_height_o     = ok ? ph_q[15:0] : 16'd0;
  assign num_columns_o       = ok ? cols : 8'd0;

endmodule

### design/tmla_chk.sv
`timescale 1ns / 1ps
// port-level checker for the tile mosaic layout address block, with bind
// depends on tmla_pkg and the top level's port names

module tmla_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [19:0] tile_address_o,
  input logic        tile_in_range_o,
  input logic [9:0]  column_width_ctus_o,
  input logic        column_in_range_o,
  input logic [15:0] merged_width_o,
  input logic [1:0]  error_code_o
);
  import tmla_pkg::*;

  // a taken item makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item taken but block not busy");

  // a result only shows while an item is in flight
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result strobe while idle");

  // block is free again right after the result
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy && !result_valid_o) else $error("no return to idle");

  // errored results carry no layout
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && error_code_o != ErrNone |->
      tile_address_o == 20'd0 && merged_width_o == 16'd0 && !tile_in_range_o)
    else $error("layout fields set on error");

  // out-of-range indices give zero address and width
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (tile_in_range_o || tile_address_o == 20'd0) &&
      (column_in_range_o || column_width_ctus_o == 10'd0))
    else $error("value reported out of range");

endmodule

bind tile_mosaic_layout_address tmla_chk u_tmla_chk (.*);
